[rtl/dhfr_pkg.sv]
// ----------------------------------------------------------------------------
// dhfr_pkg: shared types and constants of the dual header frame receiver
// Header bytes, frame byte positions and the per-byte frame record.
// ----------------------------------------------------------------------------
package dhfr_pkg;

  localparam logic [7:0] HDR_A0 = 8'h01;
  localparam logic [7:0] HDR_A1 = 8'h02;
  localparam logic [7:0] HDR_A2 = 8'h03;
  localparam logic [7:0] HDR_A3 = 8'h04;
  localparam logic [7:0] HDR_B0 = 8'hAA;
  localparam logic [7:0] HDR_B1 = 8'h85;

  localparam logic [7:0] SIGN_PLUS  = 8'h01;
  localparam logic [7:0] SIGN_MINUS = 8'h00;

  // receiver A counter: hunting, then sign, magnitude bytes, command
  localparam logic [3:0] CNT_A_HUNT = 4'd3;
  localparam logic [3:0] CNT_A_SIGN = 4'd4;
  localparam logic [3:0] CNT_A_MAG2 = 4'd5;
  localparam logic [3:0] CNT_A_MAG1 = 4'd6;
  localparam logic [3:0] CNT_A_MAG0 = 4'd7;
  localparam logic [3:0] CNT_A_CMD  = 4'd8;

  // receiver B counter: hunting (command byte taken on header hit), then
  // type byte and four value bytes
  localparam logic [3:0] CNT_B_HUNT = 4'd2;
  localparam logic [3:0] CNT_B_TYPE = 4'd3;
  localparam logic [3:0] CNT_B_VAL3 = 4'd4;
  localparam logic [3:0] CNT_B_VAL2 = 4'd5;
  localparam logic [3:0] CNT_B_VAL1 = 4'd6;
  localparam logic [3:0] CNT_B_VAL0 = 4'd7;

  localparam logic PROTO_A = 1'b0;
  localparam logic PROTO_B = 1'b1;

  // frames completed by one byte
  typedef struct packed {
    logic        has_b;
    logic [7:0]  b_cmd;
    logic [7:0]  b_type;
    logic [31:0] b_value;
    logic        has_a;
    logic [7:0]  a_cmd;
    logic [31:0] a_value;
    logic        a_valid;
  } frame_evt_t;

endpackage

[rtl/dual_header_frame_receiver.sv]
// ----------------------------------------------------------------------------
// dual_header_frame_receiver: two-protocol serial frame receiver
// Input: one received byte per transaction on in_valid / in_stall /
// in_rx_byte. Every byte is fed to both receivers (header 01 02 03 04 with a
// sign-magnitude 24-bit value, header AA 85 with a 32-bit value).
// Output: one transaction per completed frame on out_valid / out_stall.
// When one byte ends both frames, the AA 85 frame comes first; out_last
// marks the final result of that byte.
// Frame assembly feeds the queue, which feeds the output register.
// Throughput: one byte per cycle while the queue is not full; a byte ending
// two frames gives two output transactions from the single output register.
// in_stall rises only when the QUEUE_DEPTH-entry frame queue is full, so
// bytes keep flowing while a result waits on a stalled receiver.
// Reset clears the header windows, puts both receivers into hunting, and
// empties the queue and the output register.
// ----------------------------------------------------------------------------
module dual_header_frame_receiver #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_protocol,
  output logic [7:0]         out_command,
  output logic [7:0]         out_type_code,
  output logic signed [31:0] out_value,
  output logic               out_value_valid,
  output logic               out_last
);

  localparam int EVT_W = $bits(dhfr_pkg::frame_evt_t);

  dhfr_pkg::frame_evt_t front_evt, queue_evt;
  logic accept, push, pop, full, empty;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign push     = accept && (front_evt.has_a || front_evt.has_b);

  dhfr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .evt     (front_evt)
  );

  dhfr_fifo #(
    .WIDTH (EVT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (front_evt),
    .pop     (pop),
    .rd_data (queue_evt),
    .full    (full),
    .empty   (empty)
  );

  dhfr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .evt             (queue_evt),
    .evt_avail       (!empty),
    .evt_pop         (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_protocol    (out_protocol),
    .out_command     (out_command),
    .out_type_code   (out_type_code),
    .out_value       (out_value),
    .out_value_valid (out_value_valid),
    .out_last        (out_last)
  );

endmodule

[rtl/dhfr_front.sv]
// ----------------------------------------------------------------------------
// dhfr_front: header hunting and frame assembly for both receivers
// Updates both receivers on every accepted byte and reports completed frames.
// ----------------------------------------------------------------------------
module dhfr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  output dhfr_pkg::frame_evt_t  evt
);

  logic [3:0] cnt_a_r, cnt_a_nxt;
  logic [3:0] cnt_b_r, cnt_b_nxt;
  logic [7:0] win_a_r   [4];
  logic [7:0] win_a_nxt [4];
  logic [7:0] win_b_r   [2];
  logic [7:0] win_b_nxt [2];
  logic [7:0] sign_a_r, sign_a_nxt;
  logic [7:0] mag_a_r   [3];
  logic [7:0] mag_a_nxt [3];
  logic [7:0] cmd_b_r, cmd_b_nxt;
  logic [7:0] type_b_r, type_b_nxt;
  logic [7:0] val_b_r   [3];
  logic [7:0] val_b_nxt [3];
  logic [31:0] mag_ext;

  assign mag_ext = {8'h00, mag_a_r[2], mag_a_r[1], mag_a_r[0]};

  always_comb begin
    cnt_a_nxt  = cnt_a_r;
    cnt_b_nxt  = cnt_b_r;
    win_a_nxt  = win_a_r;
    win_b_nxt  = win_b_r;
    sign_a_nxt = sign_a_r;
    mag_a_nxt  = mag_a_r;
    cmd_b_nxt  = cmd_b_r;
    type_b_nxt = type_b_r;
    val_b_nxt  = val_b_r;
    evt        = '0;

    // receiver B
    if (cnt_b_r >= dhfr_pkg::CNT_B_TYPE && cnt_b_r <= dhfr_pkg::CNT_B_VAL0) begin
      cnt_b_nxt = cnt_b_r + 4'd1;
      case (cnt_b_r)
        dhfr_pkg::CNT_B_TYPE: type_b_nxt   = rx_byte;
        dhfr_pkg::CNT_B_VAL3: val_b_nxt[2] = rx_byte;
        dhfr_pkg::CNT_B_VAL2: val_b_nxt[1] = rx_byte;
        dhfr_pkg::CNT_B_VAL1: val_b_nxt[0] = rx_byte;
        dhfr_pkg::CNT_B_VAL0: begin
          evt.has_b    = 1'b1;
          evt.b_cmd    = cmd_b_r;
          evt.b_type   = type_b_r;
          evt.b_value  = {val_b_r[2], val_b_r[1], val_b_r[0], rx_byte};
          cnt_b_nxt    = dhfr_pkg::CNT_B_HUNT;
          win_b_nxt[0] = 8'h00;
          win_b_nxt[1] = 8'h00;
        end
        default: ;
      endcase
    end else begin
      cnt_b_nxt = dhfr_pkg::CNT_B_HUNT;
      if (win_b_r[0] == dhfr_pkg::HDR_B0 && win_b_r[1] == dhfr_pkg::HDR_B1) begin
        cmd_b_nxt = rx_byte;
        cnt_b_nxt = dhfr_pkg::CNT_B_TYPE;
      end
      win_b_nxt[0] = win_b_r[1];
      win_b_nxt[1] = rx_byte;
    end

    // receiver A
    if (cnt_a_r >= dhfr_pkg::CNT_A_SIGN && cnt_a_r <= dhfr_pkg::CNT_A_CMD) begin
      cnt_a_nxt = cnt_a_r + 4'd1;
      case (cnt_a_r)
        dhfr_pkg::CNT_A_SIGN: sign_a_nxt   = rx_byte;
        dhfr_pkg::CNT_A_MAG2: mag_a_nxt[2] = rx_byte;
        dhfr_pkg::CNT_A_MAG1: mag_a_nxt[1] = rx_byte;
        dhfr_pkg::CNT_A_MAG0: mag_a_nxt[0] = rx_byte;
        dhfr_pkg::CNT_A_CMD: begin
          evt.has_a = 1'b1;
          evt.a_cmd = rx_byte;
          if (sign_a_r == dhfr_pkg::SIGN_PLUS) begin
            evt.a_value = mag_ext;
            evt.a_valid = 1'b1;
          end else if (sign_a_r == dhfr_pkg::SIGN_MINUS) begin
            evt.a_value = 32'd0 - mag_ext;
            evt.a_valid = 1'b1;
          end
          cnt_a_nxt = dhfr_pkg::CNT_A_HUNT;
          for (int i = 0; i < 4; i++) win_a_nxt[i] = 8'h00;
        end
        default: ;
      endcase
    end else begin
      cnt_a_nxt    = dhfr_pkg::CNT_A_HUNT;
      win_a_nxt[0] = win_a_r[1];
      win_a_nxt[1] = win_a_r[2];
      win_a_nxt[2] = win_a_r[3];
      win_a_nxt[3] = rx_byte;
      if (win_a_r[1] == dhfr_pkg::HDR_A0 && win_a_r[2] == dhfr_pkg::HDR_A1 &&
          win_a_r[3] == dhfr_pkg::HDR_A2 && rx_byte == dhfr_pkg::HDR_A3) begin
        cnt_a_nxt = dhfr_pkg::CNT_A_SIGN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= dhfr_pkg::CNT_A_HUNT;
      cnt_b_r <= dhfr_pkg::CNT_B_HUNT;
      for (int i = 0; i < 4; i++) win_a_r[i] <= 8'h00;
      for (int i = 0; i < 2; i++) win_b_r[i] <= 8'h00;
    end else if (accept) begin
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      win_a_r <= win_a_nxt;
      win_b_r <= win_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sign_a_r <= sign_a_nxt;
      mag_a_r  <= mag_a_nxt;
      cmd_b_r  <= cmd_b_nxt;
      type_b_r <= type_b_nxt;
      val_b_r  <= val_b_nxt;
    end
  end

endmodule

[rtl/dhfr_fifo.sv]
// ----------------------------------------------------------------------------
// dhfr_fifo: small register queue between frame assembly and output
// Single push and pop port, full and empty from an occupancy count.
// ----------------------------------------------------------------------------
module dhfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r, count_nxt;

  assign rd_data = mem_r[rd_ptr_r];
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

[rtl/dhfr_back.sv]
// ----------------------------------------------------------------------------
// dhfr_back: result sequencer
// Turns each queued frame record into one or two result transactions.
// ----------------------------------------------------------------------------
module dhfr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dhfr_pkg::frame_evt_t  evt,
  input  logic                  evt_avail,
  output logic                  evt_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_protocol,
  output logic [7:0]            out_command,
  output logic [7:0]            out_type_code,
  output logic signed [31:0]    out_value,
  output logic                  out_value_valid,
  output logic                  out_last
);

  logic        valid_r, valid_nxt;
  logic        pend_a_r, pend_a_nxt;
  logic        proto_r, proto_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] value_r, value_nxt;
  logic        vvalid_r, vvalid_nxt;
  logic        last_r, last_nxt;
  logic [7:0]  hold_cmd_r, hold_cmd_nxt;
  logic [31:0] hold_value_r, hold_value_nxt;
  logic        hold_valid_r, hold_valid_nxt;
  logic        free;

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt      = valid_r;
    pend_a_nxt     = pend_a_r;
    proto_nxt      = proto_r;
    cmd_nxt        = cmd_r;
    type_nxt       = type_r;
    value_nxt      = value_r;
    vvalid_nxt     = vvalid_r;
    last_nxt       = last_r;
    hold_cmd_nxt   = hold_cmd_r;
    hold_value_nxt = hold_value_r;
    hold_valid_nxt = hold_valid_r;
    evt_pop        = 1'b0;
    if (free) begin
      valid_nxt = 1'b0;
      if (pend_a_r) begin
        valid_nxt  = 1'b1;
        pend_a_nxt = 1'b0;
        proto_nxt  = dhfr_pkg::PROTO_A;
        cmd_nxt    = hold_cmd_r;
        type_nxt   = 8'h00;
        value_nxt  = hold_value_r;
        vvalid_nxt = hold_valid_r;
        last_nxt   = 1'b1;
      end else if (evt_avail) begin
        evt_pop   = 1'b1;
        valid_nxt = 1'b1;
        if (evt.has_b) begin
          proto_nxt      = dhfr_pkg::PROTO_B;
          cmd_nxt        = evt.b_cmd;
          type_nxt       = evt.b_type;
          value_nxt      = evt.b_value;
          vvalid_nxt     = 1'b1;
          last_nxt       = !evt.has_a;
          pend_a_nxt     = evt.has_a;
          hold_cmd_nxt   = evt.a_cmd;
          hold_value_nxt = evt.a_value;
          hold_valid_nxt = evt.a_valid;
        end else begin
          proto_nxt  = dhfr_pkg::PROTO_A;
          cmd_nxt    = evt.a_cmd;
          type_nxt   = 8'h00;
          value_nxt  = evt.a_value;
          vvalid_nxt = evt.a_valid;
          last_nxt   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      pend_a_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      pend_a_r <= pend_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proto_r      <= proto_nxt;
    cmd_r        <= cmd_nxt;
    type_r       <= type_nxt;
    value_r      <= value_nxt;
    vvalid_r     <= vvalid_nxt;
    last_r       <= last_nxt;
    hold_cmd_r   <= hold_cmd_nxt;
    hold_value_r <= hold_value_nxt;
    hold_valid_r <= hold_valid_nxt;
  end

  assign out_valid       = valid_r;
  assign out_protocol    = proto_r;
  assign out_command     = cmd_r;
  assign out_type_code   = type_r;
  assign out_value       = signed'(value_r);
  assign out_value_valid = vvalid_r;
  assign out_last        = last_r;

endmodule
